### src/ftwa_pkg.sv
// Package for the frame timer with moving-average frame time.
// Holds the transaction types, operation codes, register map and reset values.
// No dependencies; every module of the block imports it.
package ftwa_pkg;

  // Field widths of the transactions.
  localparam int unsigned STAMP_W = 63;
  localparam int unsigned TICKS_W = 32;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned ACCUM_W = 33;

  // Width of the shared adder/subtractor.
  localparam int unsigned ALU_W = 64;

  // Default window depth (number of frame deltas averaged).
  localparam int unsigned WINDOW_DEPTH_DEF = 64;

  // Configuration port: two 32-bit registers at byte addresses 0 and 4.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_TICK_FREQ = 1'b0;
  localparam logic REG_MIN_FRAME = 1'b1;

  localparam logic [TICKS_W-1:0] TICK_FREQ_RESET = 32'd10000000;
  localparam logic [TICKS_W-1:0] MIN_FRAME_RESET = 32'd0;

  // Event codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  // Input transaction.
  typedef struct packed {
    logic [1:0]         operation;
    logic [STAMP_W-1:0] stamp;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [TICKS_W-1:0]        avg_frame_ticks;
    logic [TICKS_W-1:0]        frame_rate;
    logic signed [TOTAL_W-1:0] total_ticks;
    logic                      is_stopped;
    logic                      must_wait;
  } out_item_t;

  // Request to the shared adder: result is a + b, or a - b when sub is set.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

### src/frame_timer_with_average.sv
// Frame timer with moving-average frame time; top level. Uses ftwa_pkg and ftwa_alu.
// Latency: reset, stop, start while running and a tick while stopped take 3 cycles, start while
// stopped 5, a locked tick 5, an accepted tick 9 to 12 plus one cycle per window sum bit (39 at
// depth 64) for the serial divide when the window holds samples; one 64-bit adder serves all.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: asynchronous, active low; clears all timer state, the window contents are unknown.
module frame_timer_with_average import ftwa_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SUM_W  = TICKS_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START1 = 4'd1;
  localparam logic [3:0] S_START2 = 4'd2;
  localparam logic [3:0] S_DELTA  = 4'd3;
  localparam logic [3:0] S_LOCK   = 4'd4;
  localparam logic [3:0] S_DIFF   = 4'd5;
  localparam logic [3:0] S_NEG    = 4'd6;
  localparam logic [3:0] S_CMPF   = 4'd7;
  localparam logic [3:0] S_SUBOLD = 4'd8;
  localparam logic [3:0] S_ADDD   = 4'd9;
  localparam logic [3:0] S_ACC    = 4'd10;
  localparam logic [3:0] S_SEC    = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_TOT1   = 4'd13;
  localparam logic [3:0] S_TOT2   = 4'd14;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [TICKS_W-1:0] freq_q, min_q;

  // Timer state.
  logic [TICKS_W-1:0] avg_q, frames_q, rate_q;
  logic [ACCUM_W-1:0] accum_q;
  logic [STAMP_W-1:0] last_q, latest_q, base_q, paused_q, stop_q;
  logic               stopped_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PTR_W-1:0]   pos_q;
  logic [SUM_W-1:0]   sum_q;

  // Per-transaction working registers.
  logic [1:0]         op_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [TICKS_W-1:0] d_q;
  logic [ALU_W-1:0]   tmp_q;
  logic               wait_q;
  logic [SUM_W-1:0]   dq_q;
  logic [CNT_W-1:0]   rem_q;
  logic [STEP_W-1:0]  step_q;
  logic [TICKS_W-1:0] rd_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // Frame window memory.
  logic [TICKS_W-1:0] win_mem [WINDOW_DEPTH];

  alu_req_t           alu_req;
  logic [ALU_W-1:0]   alu_res;
  logic               alu_carry;

  logic               accept;
  logic               cfg_wr;
  logic               full;
  logic               out_free;
  logic [CNT_W:0]     trial;
  logic               qbit;
  logic [SUM_W-1:0]   dq_next;
  logic [STAMP_W-1:0] cur_stamp;

  ftwa_alu u_alu (
    .req_i   (alu_req),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign full        = (cnt_q == CNT_W'(WINDOW_DEPTH));
  assign cur_stamp   = stopped_q ? stop_q : latest_q;

  // Divider step: trial subtract of the divisor from the partial remainder.
  assign trial   = {rem_q, dq_q[SUM_W-1]};
  assign qbit    = alu_carry;
  assign dq_next = {dq_q[SUM_W-2:0], qbit};

  // Configuration port: zero wait states, register picked by address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_TICK_FREQ: prdata = freq_q;
      REG_MIN_FRAME: prdata = min_q;
      default:       prdata = '0;
    endcase
  end

  // Operand selection for the shared adder in each phase.
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      S_START1: alu_req = '{a: ALU_W'(stamp_q), b: ALU_W'(stop_q), sub: 1'b1};
      S_START2: alu_req = '{a: ALU_W'(paused_q), b: tmp_q, sub: 1'b0};
      S_DELTA:  alu_req = '{a: ALU_W'(stamp_q), b: ALU_W'(last_q), sub: 1'b1};
      S_LOCK:   alu_req = '{a: ALU_W'(d_q), b: ALU_W'(min_q), sub: 1'b1};
      S_DIFF:   alu_req = '{a: ALU_W'(d_q), b: ALU_W'(avg_q), sub: 1'b1};
      S_NEG:    alu_req = '{a: ALU_W'(avg_q), b: ALU_W'(d_q), sub: 1'b1};
      S_CMPF:   alu_req = '{a: tmp_q, b: ALU_W'(freq_q), sub: 1'b1};
      S_SUBOLD: alu_req = '{a: ALU_W'(sum_q), b: ALU_W'(rd_q), sub: 1'b1};
      S_ADDD:   alu_req = '{a: ALU_W'(sum_q), b: ALU_W'(d_q), sub: 1'b0};
      S_ACC:    alu_req = '{a: ALU_W'(accum_q), b: ALU_W'(d_q), sub: 1'b0};
      S_SEC:    alu_req = '{a: ALU_W'(freq_q), b: ALU_W'(accum_q), sub: 1'b1};
      S_DIV:    alu_req = '{a: ALU_W'(trial), b: ALU_W'(cnt_q), sub: 1'b1};
      S_TOT1:   alu_req = '{a: ALU_W'(cur_stamp), b: ALU_W'(paused_q), sub: 1'b1};
      S_TOT2:   alu_req = '{a: tmp_q, b: ALU_W'(base_q), sub: 1'b1};
      default:  alu_req = '0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.operation)
            OP_TICK:  state_d = stopped_q ? S_TOT1 : S_DELTA;
            OP_START: state_d = stopped_q ? S_START1 : S_TOT1;
            OP_RESET: state_d = S_TOT1;
            OP_STOP:  state_d = S_TOT1;
            default:  state_d = S_TOT1;
          endcase
        end
      end
      S_START1: state_d = S_START2;
      S_START2: state_d = S_TOT1;
      S_DELTA:  state_d = S_LOCK;
      S_LOCK:   state_d = ((min_q != '0) && !alu_carry) ? S_TOT1 : S_DIFF;
      S_DIFF:   state_d = alu_carry ? S_CMPF : S_NEG;
      S_NEG:    state_d = S_CMPF;
      S_CMPF: begin
        if (!alu_carry) begin
          state_d = full ? S_SUBOLD : S_ADDD;
        end else begin
          state_d = S_ACC;
        end
      end
      S_SUBOLD: state_d = S_ADDD;
      S_ADDD:   state_d = S_ACC;
      S_ACC:    state_d = S_SEC;
      S_SEC:    state_d = (cnt_q == '0) ? S_TOT1 : S_DIV;
      S_DIV:    state_d = (step_q == '0) ? S_TOT1 : S_DIV;
      S_TOT1:   state_d = S_TOT2;
      S_TOT2:   state_d = out_free ? S_IDLE : S_TOT2;
      default:  state_d = S_IDLE;
    endcase
  end

  // Timer state, configuration and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      freq_q      <= TICK_FREQ_RESET;
      min_q       <= MIN_FRAME_RESET;
      avg_q       <= '0;
      frames_q    <= '0;
      rate_q      <= '0;
      accum_q     <= '0;
      last_q      <= '0;
      latest_q    <= '0;
      base_q      <= '0;
      paused_q    <= '0;
      stop_q      <= '0;
      stopped_q   <= 1'b0;
      cnt_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        if (paddr[2] == REG_TICK_FREQ) begin
          freq_q <= pwdata;
        end else begin
          min_q <= pwdata;
        end
      end

      // A new result is posted as the previous one leaves or once the slot is empty.
      if ((state_q == S_TOT2) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            wait_q <= 1'b0;
            unique case (in_data_i.operation)
              OP_TICK: begin
                if (stopped_q) begin
                  avg_q <= '0;
                end
              end
              OP_RESET: begin
                base_q    <= in_data_i.stamp;
                last_q    <= in_data_i.stamp;
                stop_q    <= '0;
                stopped_q <= 1'b0;
              end
              OP_STOP: begin
                if (!stopped_q) begin
                  stop_q    <= in_data_i.stamp;
                  stopped_q <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_START2: begin
          paused_q  <= alu_res[STAMP_W-1:0];
          last_q    <= stamp_q;
          stop_q    <= '0;
          stopped_q <= 1'b0;
        end
        S_LOCK: begin
          if ((min_q != '0) && !alu_carry) begin
            wait_q <= 1'b1;
          end else begin
            last_q   <= stamp_q;
            latest_q <= stamp_q;
          end
        end
        S_SUBOLD: sum_q <= alu_res[SUM_W-1:0];
        S_ADDD: begin
          sum_q <= alu_res[SUM_W-1:0];
          if (!full) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (pos_q == PTR_W'(WINDOW_DEPTH - 1)) begin
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + PTR_W'(1);
          end
        end
        S_ACC: begin
          accum_q  <= alu_res[ACCUM_W-1:0];
          frames_q <= frames_q + TICKS_W'(1);
        end
        S_SEC: begin
          // The second is complete once the accumulated time exceeds one second.
          if (!alu_carry) begin
            rate_q   <= frames_q;
            frames_q <= '0;
            accum_q  <= '0;
          end
          if (cnt_q == '0) begin
            avg_q <= '0;
          end
        end
        S_DIV: begin
          if (step_q == '0) begin
            avg_q <= dq_next[TICKS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers that need no reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q    <= in_data_i.operation;
          stamp_q <= in_data_i.stamp;
        end
      end
      S_START1: tmp_q <= ALU_W'(alu_res[STAMP_W-1:0]);
      S_DELTA: begin
        // Frame delta modulo 2^63, saturated to 32 bits.
        if (alu_res[STAMP_W-1:TICKS_W] != '0) begin
          d_q <= '1;
        end else begin
          d_q <= alu_res[TICKS_W-1:0];
        end
      end
      S_DIFF:   tmp_q <= ALU_W'(alu_res[TICKS_W-1:0]);
      S_NEG:    tmp_q <= ALU_W'(alu_res[TICKS_W-1:0]);
      S_SEC: begin
        dq_q   <= sum_q;
        rem_q  <= '0;
        step_q <= STEP_W'(SUM_W - 1);
      end
      S_DIV: begin
        dq_q   <= dq_next;
        rem_q  <= qbit ? alu_res[CNT_W-1:0] : trial[CNT_W-1:0];
        step_q <= step_q - STEP_W'(1);
      end
      S_TOT1:   tmp_q <= alu_res;
      S_TOT2: begin
        if (out_free) begin
          out_q.avg_frame_ticks <= stopped_q ? '0 : avg_q;
          out_q.frame_rate      <= rate_q;
          out_q.total_ticks     <= signed'(alu_res);
          out_q.is_stopped      <= stopped_q;
          out_q.must_wait       <= wait_q && (op_q == OP_TICK);
        end
      end
      default: ;
    endcase
  end

  // Window memory: the oldest entry is read before it is overwritten.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_CMPF) && !alu_carry && full) begin
      rd_q <= win_mem[pos_q];
    end
    if (state_q == S_ADDD) begin
      win_mem[pos_q] <= d_q;
    end
  end

  // The sample count never exceeds the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW_DEPTH))
    else $error("sample count beyond window depth");

  // The write position stays inside the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PTR_W'(WINDOW_DEPTH - 1))
    else $error("window position out of range");

  // A transaction taken in is not followed by another in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken while busy");

  // A locked tick only happens while running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.must_wait && out_data_o.is_stopped))
    else $error("wait reported while stopped");

endmodule

### src/ftwa_alu.sv
// Shared adder/subtractor of the frame timer.
// Depends on ftwa_pkg for the operand width and the request struct.
// On subtraction the carry out is set when a >= b (unsigned).
module ftwa_alu import ftwa_pkg::*; (
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] res_o,
  output logic             carry_o
);

  logic [ALU_W-1:0] b_eff;

  // Two's complement subtraction through an inverted operand and carry in.
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign {carry_o, res_o} = {1'b0, req_i.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req_i.sub};

endmodule

### sim/ftwa_checker.sv
// Checker for the frame timer: watches both streams and the register port,
// predicts every result from its own timer model and compares it field by field.
// Depends on ftwa_pkg for the transaction types, operation codes and register map.
`timescale 1ns / 100ps

module ftwa_checker import ftwa_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_data_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  // Register copies, updated from observed writes.
  logic [TICKS_W-1:0] tick_freq_q;
  logic [TICKS_W-1:0] min_frame_q;

  // Timer model state.
  logic [TICKS_W-1:0] delta_window [WINDOW_DEPTH];
  int unsigned        write_pos;
  int unsigned        fill;
  logic [63:0]        delta_sum;
  logic [TICKS_W-1:0] avg_q;
  logic [STAMP_W-1:0] last_stamp_q;
  logic [STAMP_W-1:0] latest_stamp_q;
  logic [STAMP_W-1:0] base_stamp_q;
  logic [STAMP_W-1:0] paused_q;
  logic [STAMP_W-1:0] stop_stamp_q;
  logic               stopped_q;
  logic [TICKS_W-1:0] frames_q;
  logic [63:0]        second_ticks_q;
  logic [TICKS_W-1:0] rate_q;

  out_item_t   timer_results_q[$];
  int unsigned fail_total;

  assign mismatches_o = fail_total;

  task automatic report_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      fail_total++;
      if (fail_total <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      end
    end
  endtask

  // Push one frame delta into the circular window, dropping the oldest when full.
  task automatic push_delta(input logic [TICKS_W-1:0] delta);
    if (fill >= WINDOW_DEPTH) begin
      delta_sum = delta_sum - delta_window[write_pos];
    end else begin
      fill++;
    end
    delta_window[write_pos] = delta;
    delta_sum = delta_sum + delta;
    write_pos = (write_pos + 1 >= WINDOW_DEPTH) ? 0 : write_pos + 1;
  endtask

  // Advance the timer model by one event and form the result it reports.
  task automatic advance_timer(input in_item_t ev, output out_item_t res);
    logic [STAMP_W-1:0] raw;
    logic [STAMP_W-1:0] shown;
    logic [TICKS_W-1:0] delta;
    logic [TICKS_W-1:0] diff;
    logic               lock_hit;
    lock_hit = 1'b0;
    case (op_e'(ev.operation))
      OP_TICK: begin
        if (stopped_q) begin
          avg_q = '0;
        end else begin
          raw = ev.stamp - last_stamp_q;
          delta = (raw > 63'hFFFF_FFFF) ? 32'hFFFF_FFFF : raw[TICKS_W-1:0];
          if (min_frame_q != 0 && delta < min_frame_q) begin
            // Frame lock: too early, nothing moves.
            lock_hit = 1'b1;
          end else begin
            last_stamp_q = ev.stamp;
            latest_stamp_q = ev.stamp;
            diff = (delta >= avg_q) ? delta - avg_q : avg_q - delta;
            if (diff < tick_freq_q) begin
              push_delta(delta);
            end
            // Frame-rate count over one second of accumulated deltas.
            frames_q = frames_q + 1;
            second_ticks_q = second_ticks_q + delta;
            if (second_ticks_q > {32'd0, tick_freq_q}) begin
              rate_q = frames_q;
              frames_q = '0;
              second_ticks_q = '0;
            end
            avg_q = (fill != 0) ? TICKS_W'(delta_sum / 64'(fill)) : '0;
          end
        end
      end
      OP_RESET: begin
        base_stamp_q = ev.stamp;
        last_stamp_q = ev.stamp;
        stop_stamp_q = '0;
        stopped_q = 1'b0;
      end
      OP_START: begin
        if (stopped_q) begin
          paused_q = paused_q + (ev.stamp - stop_stamp_q);
          last_stamp_q = ev.stamp;
          stop_stamp_q = '0;
          stopped_q = 1'b0;
        end
      end
      default: begin
        if (!stopped_q) begin
          stop_stamp_q = ev.stamp;
          stopped_q = 1'b1;
        end
      end
    endcase

    shown = stopped_q ? stop_stamp_q : latest_stamp_q;
    res.avg_frame_ticks = stopped_q ? '0 : avg_q;
    res.frame_rate = rate_q;
    res.total_ticks = {1'b0, shown} - {1'b0, paused_q} - {1'b0, base_stamp_q};
    res.is_stopped = stopped_q;
    res.must_wait = lock_hit;
  endtask

  // Observe register writes, results and events at each clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_res;
    out_item_t new_res;
    if (!rst_ni) begin
      tick_freq_q = TICK_FREQ_RESET;
      min_frame_q = MIN_FRAME_RESET;
      write_pos = 0;
      fill = 0;
      delta_sum = '0;
      avg_q = '0;
      last_stamp_q = '0;
      latest_stamp_q = '0;
      base_stamp_q = '0;
      paused_q = '0;
      stop_stamp_q = '0;
      stopped_q = 1'b0;
      frames_q = '0;
      second_ticks_q = '0;
      rate_q = '0;
      fail_total = 0;
      timer_results_q.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_TICK_FREQ: tick_freq_q = pwdata;
          REG_MIN_FRAME: min_frame_q = pwdata;
          default: ;
        endcase
      end

      // Results are checked before the same edge's event is predicted.
      if (out_valid_i && out_ready_i) begin
        if (timer_results_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("%0t: result %0h arrived with none expected", $time, out_data_i);
          end
        end else begin
          exp_res = timer_results_q.pop_front();
          report_field("avg_frame_ticks", exp_res.avg_frame_ticks, out_data_i.avg_frame_ticks);
          report_field("frame_rate", exp_res.frame_rate, out_data_i.frame_rate);
          report_field("total_ticks", exp_res.total_ticks, out_data_i.total_ticks);
          report_field("is_stopped", exp_res.is_stopped, out_data_i.is_stopped);
          report_field("must_wait", exp_res.must_wait, out_data_i.must_wait);
        end
      end

      if (in_valid_i && in_ready_i) begin
        advance_timer(in_data_i, new_res);
        timer_results_q.push_back(new_res);
      end

      pending_o <= timer_results_q.size();
    end
  end

endmodule

### sim/tb_top.sv
// Testbench top for the frame timer: clock, reset, event stimulus, register
// writes, result back-pressure, watchdog and verdict.
// Depends on ftwa_pkg, frame_timer_with_average and ftwa_checker.
`timescale 1ns / 100ps

module tb_top;
  import ftwa_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned STALL_LIMIT  = 6000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [STAMP_W-1:0] STAMP_TOP = '1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned stall_count = 0;
  logic        quiet = 1'b0;
  logic        hold_pending = 1'b0;

  always #4 clk = ~clk;

  frame_timer_with_average i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ftwa_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet || ($urandom_range(99) >= 16);
    end
  end

  // Offer one event and wait until the block takes it.
  task automatic send_event(input op_e op, input logic [STAMP_W-1:0] at_stamp);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, stamp: at_stamp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has been seen.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic reg_write(input logic reg_sel, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [TICKS_W-1:0] freq, input logic [TICKS_W-1:0] min_ticks);
    settle();
    reg_write(REG_TICK_FREQ, freq);
    reg_write(REG_MIN_FRAME, min_ticks);
  endtask

  // One random phase: mostly steady frame ticks around a nominal frame length,
  // with lock-edge deltas, big jumps, backward stamps and pause/resume/reset events.
  task automatic run_phase(input logic [TICKS_W-1:0] freq, input logic [TICKS_W-1:0] min_ticks,
                           input int unsigned count, input logic hold_mid,
                           input logic drain_mid);
    logic [63:0]        frame_len;
    logic [63:0]        delta;
    logic [STAMP_W-1:0] stamp_now;
    int unsigned        pick;
    op_e                op;
    configure(freq, min_ticks);
    frame_len = 64'(freq / $urandom_range(80, 1));
    if (frame_len == 0) frame_len = 1;
    stamp_now = STAMP_W'({$urandom, $urandom});
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) begin
        if (hold_mid) hold_pending = 1'b1;
        if (drain_mid) settle();
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        delta = frame_len - frame_len / 16 + $urandom_range(32'(frame_len / 8), 0);
      end else if (pick < 80) begin
        delta = (min_ticks == 0) ? 64'($urandom_range(3, 0))
                                 : {32'd0, min_ticks} - 1 + $urandom_range(2, 0);
      end else if (pick < 88) begin
        delta = {$urandom_range(255, 0), $urandom};
      end else if (pick < 94) begin
        delta = -64'($urandom_range(1000, 1));
      end else begin
        delta = {$urandom, $urandom};
      end
      stamp_now = stamp_now + delta[STAMP_W-1:0];
      pick = $urandom_range(99);
      op = (pick < 86) ? OP_TICK : (pick < 91) ? OP_STOP : (pick < 96) ? OP_START : OP_RESET;
      send_event(op, stamp_now);
    end
  endtask

  // Main sequence: reset, directed events, random phases, drain and verdict.
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: basic ticks, a backward stamp, pause and resume.
    send_event(OP_TICK, 63'd100);
    send_event(OP_TICK, 63'd300);
    send_event(OP_TICK, 63'd250);
    send_event(OP_STOP, 63'd1000);
    send_event(OP_STOP, 63'd1500);
    send_event(OP_TICK, 63'd2000);
    send_event(OP_START, 63'd9000);
    send_event(OP_START, 63'd9500);
    send_event(OP_TICK, 63'd9600);
    // Stamp extremes and wrap-around of deltas, total time and paused time.
    send_event(OP_RESET, 63'd20000);
    send_event(OP_TICK, STAMP_TOP);
    send_event(OP_TICK, 63'd0);
    send_event(OP_RESET, STAMP_TOP);
    send_event(OP_STOP, 63'd0);
    send_event(OP_START, STAMP_TOP);
    send_event(OP_TICK, STAMP_TOP - 63'd10);

    // Frame lock just below, at and above the period, with a one-tick second.
    configure(32'd1, 32'd1000);
    send_event(OP_RESET, 63'd0);
    send_event(OP_TICK, 63'd999);
    send_event(OP_TICK, 63'd1000);
    send_event(OP_TICK, 63'd1500);
    send_event(OP_TICK, 63'd3000);

    // Both registers at their maximum: only saturated deltas pass the lock.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(OP_TICK, 63'd3000 + (63'd1 << 33));
    send_event(OP_TICK, 63'd3005 + (63'd1 << 33));
    send_event(OP_STOP, 63'd5000 + (63'd1 << 33));
    send_event(OP_TICK, 63'd6000 + (63'd1 << 33));
    send_event(OP_START, 63'd7000 + (63'd1 << 33));

    // Random phases across several register settings.
    run_phase(32'd1000, 32'd0, 200, 1'b1, 1'b0);
    run_phase(32'd1, 32'd0, 200, 1'b0, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150, 1'b0, 1'b0);
    quiet = 1'b1;
    run_phase($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(200, 0), 200, 1'b0, 1'b0);
    quiet = 1'b0;
    run_phase(32'd600, 32'd5, 200, 1'b0, 1'b0);
    run_phase(TICK_FREQ_RESET, MIN_FRAME_RESET, 250, 1'b0, 1'b0);
    run_phase($urandom_range(32'hFFFF_FFFF, 1), 32'd0, 200, 1'b0, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
